/* hdl/segx_pkg.sv */
// shared types for the segment intersection pipeline
`default_nettype none
package segx_pkg;

  typedef struct packed {
    logic valid;
    logic hit;
    logic neg_x;
    logic neg_y;
  } segx_ctl_t;

endpackage
`default_nettype wire

/* hdl/segx_front.sv */
// direction vectors, cross products and exact range test over four stages
`default_nettype none
module segx_front #(
  parameter int CB = 16
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         en,
  input  wire                         in_valid,
  input  wire logic signed [CB-1:0]   p0x,
  input  wire logic signed [CB-1:0]   p0y,
  input  wire logic signed [CB-1:0]   p1x,
  input  wire logic signed [CB-1:0]   p1y,
  input  wire logic signed [CB-1:0]   p2x,
  input  wire logic signed [CB-1:0]   p2y,
  input  wire logic signed [CB-1:0]   p3x,
  input  wire logic signed [CB-1:0]   p3y,
  output segx_pkg::segx_ctl_t         ctl,
  output logic [CB-1:0]               ax,
  output logic [CB-1:0]               ay,
  output logic [2*CB+1:0]             num_mag,
  output logic [2*CB+1:0]             den_mag,
  output logic signed [CB-1:0]        base_x,
  output logic signed [CB-1:0]        base_y
);
  localparam int DW = CB + 1;
  localparam int PW = 2 * DW;
  localparam int NS = PW + 1;
  localparam int NW = 2 * CB + 2;

  logic [3:0] vld_r;

  // stage 1
  logic signed [DW-1:0] d1x_r, d1y_r, d2x_r, d2y_r, wx_r, wy_r;
  logic signed [CB-1:0] s1_px_r, s1_py_r;
  // stage 2
  logic signed [PW-1:0] m_a_r, m_b_r, m_c_r, m_d_r, m_e_r, m_f_r;
  logic signed [DW-1:0] s2_dx_r, s2_dy_r;
  logic signed [CB-1:0] s2_px_r, s2_py_r;
  // stage 3
  logic signed [NS-1:0] den_r, s_r, t_r;
  logic signed [DW-1:0] s3_dx_r, s3_dy_r;
  logic signed [CB-1:0] s3_px_r, s3_py_r;
  // stage 4
  logic                 hit_r, negx_r, negy_r;
  logic [CB-1:0]        ax_r, ay_r;
  logic [NW-1:0]        num_r, dmag_r;
  logic signed [CB-1:0] s4_px_r, s4_py_r;

  logic                 s_ok, t_ok, hit_nxt;
  logic signed [NS-1:0] t_abs, d_abs;
  logic signed [DW-1:0] dx_abs, dy_abs;

  always_comb begin
    if (!den_r[NS-1]) begin
      s_ok = !s_r[NS-1] && (s_r <= den_r);
      t_ok = !t_r[NS-1] && (t_r <= den_r);
    end else begin
      s_ok = (s_r <= 0) && (s_r >= den_r);
      t_ok = (t_r <= 0) && (t_r >= den_r);
    end
    hit_nxt = (den_r != 0) && s_ok && t_ok;
    t_abs   = t_r[NS-1] ? -t_r : t_r;
    d_abs   = den_r[NS-1] ? -den_r : den_r;
    dx_abs  = s3_dx_r[DW-1] ? -s3_dx_r : s3_dx_r;
    dy_abs  = s3_dy_r[DW-1] ? -s3_dy_r : s3_dy_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1x_r   <= DW'(p1x) - DW'(p0x);
      d1y_r   <= DW'(p1y) - DW'(p0y);
      d2x_r   <= DW'(p3x) - DW'(p2x);
      d2y_r   <= DW'(p3y) - DW'(p2y);
      wx_r    <= DW'(p0x) - DW'(p2x);
      wy_r    <= DW'(p0y) - DW'(p2y);
      s1_px_r <= p0x;
      s1_py_r <= p0y;

      m_a_r   <= PW'(d1x_r) * PW'(d2y_r);
      m_b_r   <= PW'(d2x_r) * PW'(d1y_r);
      m_c_r   <= PW'(d1x_r) * PW'(wy_r);
      m_d_r   <= PW'(d1y_r) * PW'(wx_r);
      m_e_r   <= PW'(d2x_r) * PW'(wy_r);
      m_f_r   <= PW'(d2y_r) * PW'(wx_r);
      s2_dx_r <= d1x_r;
      s2_dy_r <= d1y_r;
      s2_px_r <= s1_px_r;
      s2_py_r <= s1_py_r;

      den_r   <= NS'(m_a_r) - NS'(m_b_r);
      s_r     <= NS'(m_c_r) - NS'(m_d_r);
      t_r     <= NS'(m_e_r) - NS'(m_f_r);
      s3_dx_r <= s2_dx_r;
      s3_dy_r <= s2_dy_r;
      s3_px_r <= s2_px_r;
      s3_py_r <= s2_py_r;

      hit_r   <= hit_nxt;
      negx_r  <= s3_dx_r[DW-1];
      negy_r  <= s3_dy_r[DW-1];
      ax_r    <= dx_abs[CB-1:0];
      ay_r    <= dy_abs[CB-1:0];
      num_r   <= t_abs[NW-1:0];
      dmag_r  <= d_abs[NW-1:0];
      s4_px_r <= s3_px_r;
      s4_py_r <= s3_py_r;
    end
  end

  assign ctl.valid = vld_r[3];
  assign ctl.hit   = hit_r;
  assign ctl.neg_x = negx_r;
  assign ctl.neg_y = negy_r;
  assign ax        = ax_r;
  assign ay        = ay_r;
  assign num_mag   = num_r;
  assign den_mag   = dmag_r;
  assign base_x    = s4_px_r;
  assign base_y    = s4_py_r;
endmodule
`default_nettype wire

/* hdl/segx_div_step.sv */
// one quotient bit of the scaled division for both coordinates
`default_nettype none
module segx_div_step #(
  parameter int CB  = 16,
  parameter int BIT = 0
) (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          en,
  input  segx_pkg::segx_ctl_t          ctl_i,
  input  wire logic [CB-1:0]           ax_i,
  input  wire logic [CB-1:0]           ay_i,
  input  wire logic [2*CB+1:0]         num_i,
  input  wire logic [2*CB+1:0]         den_i,
  input  wire logic [2*CB+1:0]         rx_i,
  input  wire logic [2*CB+1:0]         ry_i,
  input  wire logic [CB-1:0]           qx_i,
  input  wire logic [CB-1:0]           qy_i,
  input  wire logic signed [CB-1:0]    bx_i,
  input  wire logic signed [CB-1:0]    by_i,
  output segx_pkg::segx_ctl_t          ctl_o,
  output logic [CB-1:0]                ax_o,
  output logic [CB-1:0]                ay_o,
  output logic [2*CB+1:0]              num_o,
  output logic [2*CB+1:0]              den_o,
  output logic [2*CB+1:0]              rx_o,
  output logic [2*CB+1:0]              ry_o,
  output logic [CB-1:0]                qx_o,
  output logic [CB-1:0]                qy_o,
  output logic signed [CB-1:0]         bx_o,
  output logic signed [CB-1:0]         by_o
);
  localparam int NW = 2 * CB + 2;
  localparam int EW = NW + 2;

  logic                 valid_r, hit_r, negx_r, negy_r;
  logic [CB-1:0]        ax_r, ay_r, qx_r, qy_r;
  logic [NW-1:0]        num_r, den_r, rx_r, ry_r;
  logic signed [CB-1:0] bx_r, by_r;

  logic [EW-1:0] ex, ey, d1, d2, rx_nxt_w, ry_nxt_w;
  logic [CB:0]   qx_w, qy_w;

  always_comb begin
    d1 = EW'(den_i);
    d2 = EW'(den_i) << 1;
    ex = (EW'(rx_i) << 1) + (ax_i[BIT] ? EW'(num_i) : '0);
    ey = (EW'(ry_i) << 1) + (ay_i[BIT] ? EW'(num_i) : '0);
    qx_w = {qx_i, 1'b0};
    qy_w = {qy_i, 1'b0};
    if (ex >= d2) begin
      rx_nxt_w = ex - d2;
      qx_w     = qx_w + (CB+1)'(2);
    end else if (ex >= d1) begin
      rx_nxt_w = ex - d1;
      qx_w     = qx_w + (CB+1)'(1);
    end else begin
      rx_nxt_w = ex;
    end
    if (ey >= d2) begin
      ry_nxt_w = ey - d2;
      qy_w     = qy_w + (CB+1)'(2);
    end else if (ey >= d1) begin
      ry_nxt_w = ey - d1;
      qy_w     = qy_w + (CB+1)'(1);
    end else begin
      ry_nxt_w = ey;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= ctl_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      hit_r  <= ctl_i.hit;
      negx_r <= ctl_i.neg_x;
      negy_r <= ctl_i.neg_y;
      ax_r  <= ax_i;
      ay_r  <= ay_i;
      num_r <= num_i;
      den_r <= den_i;
      rx_r  <= rx_nxt_w[NW-1:0];
      ry_r  <= ry_nxt_w[NW-1:0];
      qx_r  <= qx_w[CB-1:0];
      qy_r  <= qy_w[CB-1:0];
      bx_r  <= bx_i;
      by_r  <= by_i;
    end
  end

  assign ctl_o = {valid_r, hit_r, negx_r, negy_r};
  assign ax_o  = ax_r;
  assign ay_o  = ay_r;
  assign num_o = num_r;
  assign den_o = den_r;
  assign rx_o  = rx_r;
  assign ry_o  = ry_r;
  assign qx_o  = qx_r;
  assign qy_o  = qy_r;
  assign bx_o  = bx_r;
  assign by_o  = by_r;
endmodule
`default_nettype wire

/* hdl/segment_intersection_core.sv */
// top level: segment pair in, hit flag and crossing point out
// Takes one segment pair per clock unless the result side stalls, and returns
// one result per pair, in order. Four stages form the direction vectors, the
// cross products and the exact range test, then one stage per quotient bit of
// the scaled division follows, then the output register. A stall on the result
// side freezes the whole pipeline, so in_stall follows out_stall while a result
// is waiting. Parallel, collinear or degenerate pairs report no hit with zeros.
`default_nettype none
module segment_intersection_core #(
  parameter int COORD_BITS = 16
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              in_valid,
  output logic                             in_stall,
  input  wire logic signed [COORD_BITS-1:0] in_first_start_x,
  input  wire logic signed [COORD_BITS-1:0] in_first_start_y,
  input  wire logic signed [COORD_BITS-1:0] in_first_end_x,
  input  wire logic signed [COORD_BITS-1:0] in_first_end_y,
  input  wire logic signed [COORD_BITS-1:0] in_second_start_x,
  input  wire logic signed [COORD_BITS-1:0] in_second_start_y,
  input  wire logic signed [COORD_BITS-1:0] in_second_end_x,
  input  wire logic signed [COORD_BITS-1:0] in_second_end_y,
  output logic                             out_valid,
  input  wire                              out_stall,
  output logic                             out_hit,
  output logic signed [COORD_BITS-1:0]     out_cross_x,
  output logic signed [COORD_BITS-1:0]     out_cross_y
);
  localparam int CB = COORD_BITS;
  localparam int NW = 2 * CB + 2;

  logic en;

  segx_pkg::segx_ctl_t  ctl   [CB+1];
  logic [CB-1:0]        ax    [CB+1];
  logic [CB-1:0]        ay    [CB+1];
  logic [NW-1:0]        num   [CB+1];
  logic [NW-1:0]        den   [CB+1];
  logic [NW-1:0]        rx    [CB+1];
  logic [NW-1:0]        ry    [CB+1];
  logic [CB-1:0]        qx    [CB+1];
  logic [CB-1:0]        qy    [CB+1];
  logic signed [CB-1:0] bx    [CB+1];
  logic signed [CB-1:0] by    [CB+1];

  logic                 out_valid_r, out_hit_r;
  logic signed [CB-1:0] out_x_r, out_y_r, cx_nxt, cy_nxt;

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  segx_front #(.CB(CB)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_valid(in_valid),
    .p0x     (in_first_start_x),
    .p0y     (in_first_start_y),
    .p1x     (in_first_end_x),
    .p1y     (in_first_end_y),
    .p2x     (in_second_start_x),
    .p2y     (in_second_start_y),
    .p3x     (in_second_end_x),
    .p3y     (in_second_end_y),
    .ctl     (ctl[0]),
    .ax      (ax[0]),
    .ay      (ay[0]),
    .num_mag (num[0]),
    .den_mag (den[0]),
    .base_x  (bx[0]),
    .base_y  (by[0])
  );

  assign rx[0] = '0;
  assign ry[0] = '0;
  assign qx[0] = '0;
  assign qy[0] = '0;

  for (genvar i = 0; i < CB; i++) begin : g_div
    segx_div_step #(.CB(CB), .BIT(CB - 1 - i)) u_step (
      .clk  (clk),
      .rst_n(rst_n),
      .en   (en),
      .ctl_i(ctl[i]),   .ax_i(ax[i]),   .ay_i(ay[i]),
      .num_i(num[i]),   .den_i(den[i]), .rx_i(rx[i]),   .ry_i(ry[i]),
      .qx_i (qx[i]),    .qy_i(qy[i]),   .bx_i(bx[i]),   .by_i(by[i]),
      .ctl_o(ctl[i+1]), .ax_o(ax[i+1]), .ay_o(ay[i+1]),
      .num_o(num[i+1]), .den_o(den[i+1]), .rx_o(rx[i+1]), .ry_o(ry[i+1]),
      .qx_o (qx[i+1]),  .qy_o(qy[i+1]), .bx_o(bx[i+1]), .by_o(by[i+1])
    );
  end

  always_comb begin
    cx_nxt = '0;
    cy_nxt = '0;
    if (ctl[CB].hit) begin
      cx_nxt = ctl[CB].neg_x ? bx[CB] - $signed(qx[CB]) : bx[CB] + $signed(qx[CB]);
      cy_nxt = ctl[CB].neg_y ? by[CB] - $signed(qy[CB]) : by[CB] + $signed(qy[CB]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= ctl[CB].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r <= ctl[CB].hit;
      out_x_r   <= cx_nxt;
      out_y_r   <= cy_nxt;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_hit     = out_hit_r;
  assign out_cross_x = out_x_r;
  assign out_cross_y = out_y_r;

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_cross_x == '0 && out_cross_y == '0)
    else $error("no-hit result carries a nonzero point");

  a_stall_link: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the output side");

  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

  a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_cross_x) && $stable(out_cross_y))
    else $error("stalled result changed");
endmodule
`default_nettype wire
